FILE: rtl/core/rounded_rect_alpha_over_compositor_macros.svh
// assertion macros for the compositor checker
// expects i_clk and i_rst_n in the scope of use
`ifndef ROUNDED_RECT_ALPHA_OVER_COMPOSITOR_MACROS_SVH
`define ROUNDED_RECT_ALPHA_OVER_COMPOSITOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define RRAC_CHK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("compositor check failed");

// next-cycle implication, disabled during reset
`define RRAC_CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("compositor check failed");

`endif

FILE: rtl/core/rrac_pkg.sv
// types and constants shared by the compositor pipeline
// no dependencies
`timescale 1ns / 1ps

package rrac_pkg;

    localparam int unsigned MAX_DIMENSION = 4096;
    localparam int unsigned DIV_STEPS     = 8;

    // configuration register indexes
    localparam logic [2:0] CFG_BG_RED    = 3'd0;
    localparam logic [2:0] CFG_BG_GREEN  = 3'd1;
    localparam logic [2:0] CFG_BG_BLUE   = 3'd2;
    localparam logic [2:0] CFG_BG_ALPHA  = 3'd3;
    localparam logic [2:0] CFG_RADIUS    = 3'd4;
    localparam logic [2:0] CFG_WIDTH     = 3'd5;
    localparam logic [2:0] CFG_HEIGHT    = 3'd6;

    // mask stage result
    typedef struct packed {
        logic             outside;
        logic [7:0]       sa;
        logic [7:0]       da;
        logic [2:0][15:0] p;
    } t_msk;

    // one division lane: partial remainder and quotient bits so far
    typedef struct packed {
        logic [23:0] rem;
        logic [7:0]  quo;
    } t_lane;

    // item travelling through the divider stages
    typedef struct packed {
        t_lane [3:0] lane;
        logic [15:0] a2;
        logic        blend;
        logic        outside;
        logic [7:0]  da;
    } t_div;

endpackage

FILE: rtl/core/rrac_pix_if.sv
// input channel: pixel position and text sample
// depends on nothing
`timescale 1ns / 1ps

interface rrac_pix_if;
    logic        valid;
    logic        ready;
    logic [11:0] pixel_row;
    logic [11:0] pixel_col;
    logic [7:0]  text_red;
    logic [7:0]  text_green;
    logic [7:0]  text_blue;
    logic [7:0]  text_alpha;

    modport source (output valid, pixel_row, pixel_col, text_red, text_green, text_blue,
                    text_alpha, input ready);
    modport sink   (input valid, pixel_row, pixel_col, text_red, text_green, text_blue,
                    text_alpha, output ready);
endinterface

FILE: rtl/core/rrac_out_if.sv
// output channel: composited pixel
// depends on nothing
`timescale 1ns / 1ps

interface rrac_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

FILE: rtl/core/rounded_rect_alpha_over_compositor.sv
// Rounded-rectangle background with text composited over it.
// Channels: i_pix (valid/ready) takes one pixel position and its text RGBA
// sample per transaction; o_res (valid/ready) returns one composited RGBA
// pixel per transaction, in input order.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0..2 background colour, 3 background alpha, 4 radius, 5 width,
// 6 height); write only while the pipeline is empty.
// Throughput: one pixel per cycle; the pipeline is two mask stages, two
// blend stages, eight restoring divider stages (one colour quotient bit
// each) and an output register; alpha over 255 is a shift-and-add.
// A stall at the output freezes every stage at once; i_pix.ready drops
// only while a finished result waits, so nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and restores the
// register defaults: colour 50/50/50, alpha 128, radius 4, size 200 x 50.
// Pixels outside the image come out as all zero.
// depends on rrac_pkg, rrac_pix_if, rrac_out_if, rrac_mask, rrac_div_step
`timescale 1ns / 1ps

module rounded_rect_alpha_over_compositor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_data,
    rrac_pix_if.sink    i_pix,
    rrac_out_if.source  o_res
);

    logic              en;
    logic [7:0]        r_bg_red, r_bg_green, r_bg_blue, r_bg_alpha, r_radius;
    logic [12:0]       r_width, r_height;

    logic              msk_vld;
    rrac_pkg::t_msk    msk;

    logic              r_vld3;
    rrac_pkg::t_msk    r_m3;
    logic [2:0][15:0]  r_q3;
    logic [15:0]       r_m3a;
    logic [15:0]       r_sa255;
    logic [7:0]        r_wa3;

    logic              r_vld4;
    rrac_pkg::t_div    r_d4, n_d4;
    logic [15:0]       a2_rnd;

    logic              dv_vld [rrac_pkg::DIV_STEPS + 1];
    rrac_pkg::t_div    dv_d   [rrac_pkg::DIV_STEPS + 1];

    logic              r_ovld;
    logic [3:0][7:0]   r_opix;
    logic [7:0]        bg_c [3];

    // the whole pipe moves unless a finished result is held
    assign en          = !r_ovld || o_res.ready;
    assign i_pix.ready = en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg_red   <= 8'd50;
            r_bg_green <= 8'd50;
            r_bg_blue  <= 8'd50;
            r_bg_alpha <= 8'd128;
            r_radius   <= 8'd4;
            r_width    <= 13'd200;
            r_height   <= 13'd50;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rrac_pkg::CFG_BG_RED:   r_bg_red   <= i_cfg_data[7:0];
                rrac_pkg::CFG_BG_GREEN: r_bg_green <= i_cfg_data[7:0];
                rrac_pkg::CFG_BG_BLUE:  r_bg_blue  <= i_cfg_data[7:0];
                rrac_pkg::CFG_BG_ALPHA: r_bg_alpha <= i_cfg_data[7:0];
                rrac_pkg::CFG_RADIUS:   r_radius   <= i_cfg_data[7:0];
                rrac_pkg::CFG_WIDTH:    r_width    <= i_cfg_data;
                rrac_pkg::CFG_HEIGHT:   r_height   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign bg_c[0] = r_bg_red;
    assign bg_c[1] = r_bg_green;
    assign bg_c[2] = r_bg_blue;

    // mask stages
    rrac_mask u_mask (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_vld      (i_pix.valid),
        .i_row      (i_pix.pixel_row),
        .i_col      (i_pix.pixel_col),
        .i_sc       ({i_pix.text_blue, i_pix.text_green, i_pix.text_red}),
        .i_sa       (i_pix.text_alpha),
        .i_radius   (r_radius),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_bg_alpha (r_bg_alpha),
        .o_vld      (msk_vld),
        .o_msk      (msk)
    );

    // blend stage one: background products and alpha terms
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
        end else if (en) begin
            r_vld3 <= msk_vld;
        end
        if (en) begin
            r_m3    <= msk;
            r_wa3   <= 8'd255 - msk.sa;
            r_m3a   <= 16'(msk.da * (8'd255 - msk.sa));
            r_sa255 <= {msk.sa, 8'd0} - {8'd0, msk.sa};
            for (int k = 0; k < 3; k++) begin
                r_q3[k] <= 16'(bg_c[k] * msk.da);
            end
        end
    end

    // blend stage two: numerators, scaled alpha and alpha over 255
    always_comb begin
        n_d4         = '0;
        n_d4.a2      = r_sa255 + r_m3a;
        n_d4.blend   = (r_m3.sa != 8'd0);
        n_d4.outside = r_m3.outside;
        n_d4.da      = r_m3.da;
        for (int k = 0; k < 3; k++) begin
            n_d4.lane[k].rem = ({r_m3.p[k], 8'd0} - {8'd0, r_m3.p[k]})
                             + 24'(r_q3[k] * r_wa3);
        end
        // exact truncating divide by 255 for a scaled alpha up to 255 * 255
        a2_rnd           = n_d4.a2 + {8'd0, n_d4.a2[15:8]} + 16'd1;
        n_d4.lane[3].quo = a2_rnd[15:8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
        end else if (en) begin
            r_vld4 <= r_vld3;
        end
        if (en) begin
            r_d4 <= n_d4;
        end
    end

    // divider stages, most significant quotient bit first
    assign dv_vld[0] = r_vld4;
    assign dv_d[0]   = r_d4;

    for (genvar g = 0; g < rrac_pkg::DIV_STEPS; g++) begin : g_div
        rrac_div_step #(
            .STEP (rrac_pkg::DIV_STEPS - 1 - g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (dv_vld[g]),
            .i_d     (dv_d[g]),
            .o_vld   (dv_vld[g + 1]),
            .o_d     (dv_d[g + 1])
        );
    end

    // output register: select zero, background or blended pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= dv_vld[rrac_pkg::DIV_STEPS];
        end
        if (en) begin
            if (dv_d[rrac_pkg::DIV_STEPS].outside) begin
                r_opix <= '0;
            end else if (!dv_d[rrac_pkg::DIV_STEPS].blend) begin
                r_opix <= {dv_d[rrac_pkg::DIV_STEPS].da, r_bg_blue, r_bg_green, r_bg_red};
            end else begin
                for (int k = 0; k < 4; k++) begin
                    r_opix[k] <= dv_d[rrac_pkg::DIV_STEPS].lane[k].quo;
                end
            end
        end
    end

    assign o_res.valid     = r_ovld;
    assign o_res.out_red   = r_opix[0];
    assign o_res.out_green = r_opix[1];
    assign o_res.out_blue  = r_opix[2];
    assign o_res.out_alpha = r_opix[3];

endmodule

FILE: rtl/core/rrac_mask.sv
// two-stage corner mask: corner offsets, then distance test and text products
// depends on rrac_pkg
`timescale 1ns / 1ps

module rrac_mask (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [11:0]          i_row,
    input  logic [11:0]          i_col,
    input  logic [2:0][7:0]      i_sc,
    input  logic [7:0]           i_sa,
    input  logic [7:0]           i_radius,
    input  logic [12:0]          i_width,
    input  logic [12:0]          i_height,
    input  logic [7:0]           i_bg_alpha,
    output logic                 o_vld,
    output rrac_pkg::t_msk       o_msk
);

    localparam logic [12:0] MaxDim = 13'(rrac_pkg::MAX_DIMENSION);

    logic [12:0]        w_sat, h_sat;
    logic signed [13:0] s_r, s_row, s_col, s_wr, s_hr, s_dx, s_dy;
    logic               cl, ct, cr, cb;

    logic               r_vld1, n_outside;
    logic               r_outside;
    logic [7:0]         r_dx, r_dy, r_sa;
    logic [2:0][7:0]    r_sc;

    logic [16:0]        dsq;
    logic [15:0]        rr;

    // corner classification
    always_comb begin
        w_sat = (i_width  > MaxDim) ? MaxDim : i_width;
        h_sat = (i_height > MaxDim) ? MaxDim : i_height;
        s_r   = $signed({6'd0, i_radius});
        s_row = $signed({2'd0, i_row});
        s_col = $signed({2'd0, i_col});
        s_wr  = $signed({1'b0, w_sat}) - s_r;
        s_hr  = $signed({1'b0, h_sat}) - s_r;
        cl    = s_col < s_r;
        ct    = s_row < s_r;
        cr    = s_col >= s_wr;
        cb    = s_row >= s_hr;
        s_dx  = '0;
        s_dy  = '0;
        if (cl && ct) begin
            s_dx = s_r - s_col - 14'sd1;
            s_dy = s_r - s_row - 14'sd1;
        end else if (cr && ct) begin
            s_dx = s_col - s_wr;
            s_dy = s_r - s_row - 14'sd1;
        end else if (cl && cb) begin
            s_dx = s_r - s_col - 14'sd1;
            s_dy = s_row - s_hr;
        end else if (cr && cb) begin
            s_dx = s_col - s_wr;
            s_dy = s_row - s_hr;
        end
        n_outside = ({1'b0, i_row} >= h_sat) || ({1'b0, i_col} >= w_sat);
    end

    // stage one registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
        end
        if (i_en) begin
            r_outside <= n_outside;
            r_dx      <= s_dx[7:0];
            r_dy      <= s_dy[7:0];
            r_sa      <= i_sa;
            r_sc      <= i_sc;
        end
    end

    // distance test against the radius
    always_comb begin
        dsq = 17'(r_dx * r_dx) + 17'(r_dy * r_dy);
        rr  = 16'(i_radius * i_radius);
    end

    // stage two registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= r_vld1;
        end
        if (i_en) begin
            o_msk.outside <= r_outside;
            o_msk.sa      <= r_sa;
            o_msk.da      <= (dsq <= {1'b0, rr}) ? i_bg_alpha : 8'd0;
            for (int k = 0; k < 3; k++) begin
                o_msk.p[k] <= 16'(r_sc[k] * r_sa);
            end
        end
    end

endmodule

FILE: rtl/core/rrac_div_step.sv
// one restoring division stage: settles one quotient bit in the three colour lanes
// depends on rrac_pkg
`timescale 1ns / 1ps

module rrac_div_step #(
    parameter int STEP = 7
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  rrac_pkg::t_div i_d,
    output logic           o_vld,
    output rrac_pkg::t_div o_d
);

    logic [23:0]    dvs [3];
    rrac_pkg::t_div n_d;

    // trial subtract of the shifted divisor; the alpha lane passes through
    always_comb begin
        n_d = i_d;
        for (int k = 0; k < 3; k++) begin
            dvs[k] = {8'd0, i_d.a2} << STEP;
            if (i_d.lane[k].rem >= dvs[k]) begin
                n_d.lane[k].rem       = i_d.lane[k].rem - dvs[k];
                n_d.lane[k].quo[STEP] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
        if (i_en) begin
            o_d <= n_d;
        end
    end

endmodule

FILE: rtl/core/rrac_checker.sv
// port-level checks for the compositor, attached by bind
// depends on rounded_rect_alpha_over_compositor_macros.svh
`timescale 1ns / 1ps
`include "rounded_rect_alpha_over_compositor_macros.svh"

module rrac_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [31:0] i_out_pix
);

    // a held result stays offered
    `RRAC_CHK_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)

    // a held result keeps its pixel
    `RRAC_CHK_NEXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_out_pix))

    // input back-pressure only while a result waits
    `RRAC_CHK_NOW(a_in_stall, !i_in_ready, i_out_valid && !i_out_ready)

    // pipeline empty straight after reset
    `RRAC_CHK_NOW(a_rst_empty, !$past(i_rst_n), !i_out_valid)

endmodule

bind rounded_rect_alpha_over_compositor rrac_checker u_rrac_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_pix   ({o_res.out_alpha, o_res.out_blue, o_res.out_green, o_res.out_red})
);
